@@ rtl/sctm_pkg.sv @@
`default_nettype none
package sctm_pkg;
   localparam int COMMAND_MAX  = 32;
   localparam int ARGUMENT_MAX = 32;
   localparam int CNT_W = $clog2(COMMAND_MAX + 1);
   localparam int ARG_W = $clog2(ARGUMENT_MAX + 1);
   localparam int LEVELS = 5;
   localparam int SLOTS  = 4;
   localparam int KW_CHARS = 8;
   localparam logic [5:0] POS_SAT = 6'd63;

   typedef enum logic [1:0] {
      PH_COMMAND = 2'd0,
      PH_SKIP    = 2'd1,
      PH_ARGS    = 2'd2
   } phase_type;

   // classified byte from the front end to the back end
   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_FEED    = 2'd1,
      OP_END_TOK = 2'd2
   } op_type;

   // close_tok: final byte of a frame still in command phase ends the open token
   typedef struct packed {
      op_type      op;
      logic        emit_arg;
      logic        verdict;
      logic        close_tok;
      logic [7:0]  data;
   } item_type;

   typedef logic [KW_CHARS*8-1:0] kw_type;

   // keyword text (upper case), first char in high byte, zero padded
   function automatic kw_type kw_word(input logic [2:0] lv, input logic [1:0] s);
      kw_type r;
      unique case ({lv, s})
         5'b000_00: r = {"SOURCE", 16'h0000};
         5'b000_01: r = {"MEASURE", 8'h00};
         5'b000_10: r = {"OUTPUT", 16'h0000};
         5'b000_11: r = {"SYSTEM", 16'h0000};
         5'b001_00: r = {"VOLTAGE", 8'h00};
         5'b001_01: r = {"CURRENT", 8'h00};
         5'b001_10: r = "VOLTAGE?";
         5'b001_11: r = "CURRENT?";
         5'b010_00: r = "VOLTAGE?";
         5'b010_01: r = "CURRENT?";
         5'b011_00: r = {"ONOFF", 24'h000000};
         5'b011_01: r = {"ONOFF?", 16'h0000};
         5'b100_00: r = "VERSION?";
         5'b100_01: r = {"ERROR?", 16'h0000};
         default:   r = '0;
      endcase
      return r;
   endfunction

   // keyword character at a position; 0 past the end
   function automatic logic [7:0] kw_char(input logic [2:0] lv, input logic [1:0] s,
                                          input logic [5:0] p);
      kw_type     w;
      logic [7:0] c;
      w = kw_word(lv, s);
      c = 8'h00;
      if (p < 6'd8) c = w[{3'd7 - p[2:0], 3'b000} +: 8];
      return c;
   endfunction

   function automatic logic [3:0] kw_len(input logic [2:0] lv, input logic [1:0] s);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < KW_CHARS; i++)
         if (kw_char(lv, s, 6'(i)) != 8'h00) n = 4'(i + 1);
      return n;
   endfunction

   function automatic logic [2:0] kw_child(input logic [2:0] lv, input logic [1:0] s);
      return (lv == 3'd0) ? 3'(s) + 3'd1 : 3'd0;
   endfunction

   function automatic logic kw_callable(input logic [2:0] lv, input logic [1:0] s);
      logic r;
      unique case (lv)
         3'd1:      r = 1'b1;
         3'd2, 3'd3: r = ~s[1];
         default:   r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_id(input logic [2:0] lv, input logic [1:0] s);
      logic [2:0] r;
      unique case (lv)
         3'd1:    r = {1'b0, s};
         3'd2:    r = s[1] ? 3'd0 : {2'b10, s[0]};
         3'd3:    r = s[1] ? 3'd0 : {2'b11, s[0]};
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction
endpackage
`default_nettype wire

@@ rtl/sctm_front.sv @@
`default_nettype none
module sctm_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_frame_end,
   output logic                    q_valid,
   input  wire logic               q_ready,
   output sctm_pkg::item_type      q_item
);
   import sctm_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cmd_cnt_ff, cmd_cnt_in;
   logic [ARG_W-1:0] arg_cnt_ff, arg_cnt_in;
   item_type         it;
   logic             ws, delim, take;

   assign req_ready = q_ready;
   assign q_valid   = req_valid;
   assign q_item    = it;
   assign take      = req_valid & q_ready;
   assign ws    = (req_rx_byte == 8'h20) || (req_rx_byte >= 8'h09 && req_rx_byte <= 8'h0D);
   assign delim = (req_rx_byte == 8'h20) || (req_rx_byte == 8'h0A) || (req_rx_byte == 8'h0D);

   // classify the byte and advance the frame phase
   always_comb begin
      logic [1:0] ph;
      phase_in   = phase_ff;
      cmd_cnt_in = cmd_cnt_ff;
      arg_cnt_in = arg_cnt_ff;
      it         = '{op: OP_NONE, emit_arg: 1'b0, verdict: req_frame_end,
                     close_tok: req_frame_end & (phase_ff == PH_COMMAND),
                     data: req_rx_byte};
      ph         = phase_ff;
      if (phase_ff == PH_COMMAND) begin
         if (delim) begin
            it.op    = OP_END_TOK;
            phase_in = PH_SKIP;
         end else if (cmd_cnt_ff < CNT_W'(COMMAND_MAX - 1)) begin
            cmd_cnt_in = cmd_cnt_ff + 1'b1;
            if (req_rx_byte == 8'h00) begin
               it.op      = OP_END_TOK;
               cmd_cnt_in = CNT_W'(COMMAND_MAX - 1);
            end else if (req_rx_byte == ":") begin
               it.op = OP_END_TOK;
            end else begin
               it.op = OP_FEED;
            end
         end
      end else begin
         if (phase_ff == PH_SKIP && !ws) begin
            ph       = PH_ARGS;
            phase_in = PH_ARGS;
         end
         if (ph == PH_ARGS && !req_frame_end && arg_cnt_ff < ARG_W'(ARGUMENT_MAX - 1)) begin
            arg_cnt_in  = arg_cnt_ff + 1'b1;
            it.emit_arg = 1'b1;
         end
      end
      if (req_frame_end) begin
         phase_in   = PH_COMMAND;
         cmd_cnt_in = '0;
         arg_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COMMAND;
         cmd_cnt_ff <= '0;
         arg_cnt_ff <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         cmd_cnt_ff <= cmd_cnt_in;
         arg_cnt_ff <= arg_cnt_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/sctm_queue.sv @@
`default_nettype none
module sctm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sctm_pkg::item_type in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output sctm_pkg::item_type      out_item
);
   import sctm_pkg::*;

   // two-entry queue
   item_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

@@ rtl/sctm_back.sv @@
`default_nettype none
module sctm_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   output logic                    q_ready,
   input  wire sctm_pkg::item_type q_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_is_verdict,
   output logic [7:0]              rsp_arg_byte,
   output logic                    rsp_command_found,
   output logic [2:0]              rsp_command_id
);
   import sctm_pkg::*;

   logic [2:0] level_ff, level_in;
   logic [5:0] pos_ff, pos_in;
   logic [3:0] mask_ff, mask_in;
   logic       call_ff, call_in;
   logic [2:0] id_ff, id_in;
   logic       seen_ff, seen_in;
   logic       ov_ff;
   logic       ov_verdict_ff, ov_found_ff;
   logic [7:0] ov_byte_ff;
   logic [2:0] ov_id_ff;
   logic       take, emit, found;
   logic [2:0] lv;

   assign q_ready = ~ov_ff | rsp_ready;
   assign take    = q_valid & q_ready;
   assign lv      = (level_ff < 3'(LEVELS)) ? level_ff : 3'd0;

   // token matcher: per-slot compare against the keyword table
   always_comb begin
      logic       tok_end, hit;
      logic [5:0] pos_f;
      logic [3:0] mask_f;
      level_in = level_ff;
      call_in  = call_ff;
      id_in    = id_ff;
      seen_in  = seen_ff;
      pos_f    = pos_ff;
      mask_f   = mask_ff;
      tok_end  = (q_item.op == OP_END_TOK) || q_item.close_tok;
      hit = 1'b0;
      if (q_item.op == OP_FEED) begin
         for (int s = 0; s < SLOTS; s++)
            if (mask_ff[s] && (pos_ff >= 6'(kw_len(lv, 2'(s))) ||
                fold(kw_char(lv, 2'(s), pos_ff)) != fold(q_item.data)))
               mask_f[s] = 1'b0;
         if (pos_ff < POS_SAT) pos_f = pos_ff + 6'd1;
      end
      pos_in  = pos_f;
      mask_in = mask_f;
      // token end sees the token including a byte fed in the same transfer
      if (tok_end) begin
         if (pos_f != 6'd0) begin
            for (int s = 0; s < SLOTS; s++)
               if (!hit && mask_f[s] && 6'(kw_len(lv, 2'(s))) == pos_f) begin
                  hit     = 1'b1;
                  seen_in = 1'b1;
                  call_in = kw_callable(lv, 2'(s));
                  id_in   = kw_id(lv, 2'(s));
                  if (kw_child(lv, 2'(s)) != 3'd0) level_in = kw_child(lv, 2'(s));
               end
         end
         pos_in  = 6'd0;
         mask_in = 4'hF;
      end
   end

   // verdict sees the state left by this byte, open token closed
   assign found = seen_in & call_in;
   assign emit  = q_item.verdict | q_item.emit_arg;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 3'd0;
         pos_ff   <= 6'd0;
         mask_ff  <= 4'hF;
         call_ff  <= 1'b0;
         id_ff    <= 3'd0;
         seen_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         if (take) begin
            if (q_item.verdict) begin
               level_ff <= 3'd0;
               pos_ff   <= 6'd0;
               mask_ff  <= 4'hF;
               call_ff  <= 1'b0;
               id_ff    <= 3'd0;
               seen_ff  <= 1'b0;
            end else begin
               level_ff <= level_in;
               pos_ff   <= pos_in;
               mask_ff  <= mask_in;
               call_ff  <= call_in;
               id_ff    <= id_in;
               seen_ff  <= seen_in;
            end
         end
         if (take) ov_ff <= emit;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (take) begin
         ov_verdict_ff <= q_item.verdict;
         ov_byte_ff    <= q_item.verdict ? 8'h00 : q_item.data;
         ov_found_ff   <= q_item.verdict & found;
         ov_id_ff      <= (q_item.verdict & found) ? id_in : 3'd0;
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_is_verdict    = ov_verdict_ff;
   assign rsp_arg_byte      = ov_byte_ff;
   assign rsp_command_found = ov_found_ff;
   assign rsp_command_id    = ov_id_ff;
endmodule
`default_nettype wire

@@ rtl/scpi_command_tree_matcher_top.sv @@
// Datapath: the front end classifies each byte combinationally into the queue;
//   the back end registers any result that the byte produces.
// Throughput: one byte per cycle while results are accepted; the two-entry queue decouples the sides.
// Reset: synchronous active-high reset returns to the command phase at the
//   root level with an empty queue and no pending result.
`default_nettype none
module scpi_command_tree_matcher_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_is_verdict,
   output logic [7:0]      rsp_arg_byte,
   output logic            rsp_command_found,
   output logic [2:0]      rsp_command_id
);
   import sctm_pkg::*;

   logic     f_valid, f_ready, b_valid, b_ready;
   item_type f_item, b_item;

   sctm_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_rx_byte, .req_frame_end,
      .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
   );

   sctm_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
   );

   sctm_back u_back (
      .clock, .reset,
      .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
      .rsp_valid, .rsp_ready, .rsp_is_verdict, .rsp_arg_byte,
      .rsp_command_found, .rsp_command_id
   );
endmodule
`default_nettype wire

@@ bench/scpi_command_tree_matcher_top_tb.sv @@
`default_nettype none
module scpi_command_tree_matcher_top_tb;
   import sctm_pkg::*;

   localparam int ITEMS_TARGET = 1300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_frame_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_verdict;
   logic [7:0] rsp_arg_byte;
   logic       rsp_command_found;
   logic [2:0] rsp_command_id;

   typedef struct {
      logic       is_verdict;
      logic [7:0] arg;
      logic       found;
      logic [2:0] id;
   } parse_result_type;

   typedef struct {
      logic [7:0] b;
      logic       last;
      logic       typed;
      logic       found;
      logic [2:0] id;
   } stim_row_type;

   parse_result_type expected_q[$];
   stim_row_type     directed_rows[$];
   bit            failed = 1'b0;
   int unsigned   cycle_count = 0;
   int unsigned   bytes_sent = 0;

   // keyword tree, upper case; level 0 children sit at levels 1 to 4
   string keyword_text [5][4] = '{
      '{"SOURCE", "MEASURE", "OUTPUT", "SYSTEM"},
      '{"VOLTAGE", "CURRENT", "VOLTAGE?", "CURRENT?"},
      '{"VOLTAGE?", "CURRENT?", "", ""},
      '{"ONOFF", "ONOFF?", "", ""},
      '{"VERSION?", "ERROR?", "", ""}
   };

   // matcher shadow state
   phase_type  m_phase;
   int         m_cmd_cnt, m_arg_cnt, m_tok_pos;
   int         m_level;
   logic [3:0] m_live;
   logic       m_callable, m_seen;
   logic [2:0] m_id;

   scpi_command_tree_matcher_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_verdict   (rsp_is_verdict),
      .rsp_arg_byte     (rsp_arg_byte),
      .rsp_command_found(rsp_command_found),
      .rsp_command_id   (rsp_command_id)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] upcase(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic void clear_frame();
      m_phase = PH_COMMAND;
      m_cmd_cnt = 0;
      m_arg_cnt = 0;
      m_level = 0;
      m_tok_pos = 0;
      m_live = 4'hF;
      m_callable = 1'b0;
      m_id = 3'd0;
      m_seen = 1'b0;
   endfunction

   function automatic void take_char(logic [7:0] c);
      int n;
      for (int s = 0; s < 4; s++) begin
         n = keyword_text[m_level][s].len();
         if (m_live[s] && (m_tok_pos >= n ||
             8'(keyword_text[m_level][s][m_tok_pos]) != upcase(c)))
            m_live[s] = 1'b0;
      end
      if (m_tok_pos < 63) m_tok_pos++;
   endfunction

   // close the open token: first live keyword of exact length wins
   function automatic void close_token();
      if (m_tok_pos != 0) begin
         for (int s = 0; s < 4; s++) begin
            if (m_live[s] && keyword_text[m_level][s].len() == m_tok_pos) begin
               m_seen = 1'b1;
               m_callable = (m_level == 1) || ((m_level == 2 || m_level == 3) && s < 2);
               m_id = (m_level == 1) ? 3'(s) : (m_level == 2 && s < 2) ? 3'(4 + s) :
                      (m_level == 3 && s < 2) ? 3'(6 + s) : 3'd0;
               if (m_level == 0) m_level = s + 1;
               break;
            end
         end
      end
      m_tok_pos = 0;
      m_live = 4'hF;
   endfunction

   // advance the shadow matcher by one byte; returns 1 with a result if one is due
   function automatic bit parse_byte(logic [7:0] c, logic last, output parse_result_type r);
      bit got;
      got = 1'b0;
      r = '{1'b0, 8'h00, 1'b0, 3'd0};
      if (m_phase == PH_COMMAND) begin
         if (c == 8'h20 || c == 8'h0A || c == 8'h0D) begin
            close_token();
            m_phase = PH_SKIP;
         end else if (m_cmd_cnt < COMMAND_MAX - 1) begin
            m_cmd_cnt++;
            if (c == 8'h00) begin
               close_token();
               m_cmd_cnt = COMMAND_MAX - 1;
            end else if (c == ":") close_token();
            else take_char(c);
         end
      end else begin
         if (m_phase == PH_SKIP && !(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)))
            m_phase = PH_ARGS;
         if (m_phase != PH_SKIP && !last && m_arg_cnt < ARGUMENT_MAX - 1) begin
            m_arg_cnt++;
            r.arg = c;
            got = 1'b1;
         end
      end
      if (last) begin
         if (m_phase == PH_COMMAND) close_token();
         r.is_verdict = 1'b1;
         r.arg = 8'h00;
         r.found = m_seen && m_callable;
         r.id = r.found ? m_id : 3'd0;
         got = 1'b1;
         clear_frame();
      end
      return got;
   endfunction

   // offer one byte and hold it until transferred; burst gaps come from the caller
   task automatic send_byte(stim_row_type row);
      parse_result_type r;
      req_valid <= 1'b1;
      req_rx_byte <= row.b;
      req_frame_end <= row.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (parse_byte(row.b, row.last, r)) begin
         if (row.typed) begin
            r.found = row.found;
            r.id = row.id;
         end
         expected_q.push_back(r);
      end
   endtask

   function automatic void add_frame(string s, bit typed, bit found, logic [2:0] id);
      for (int i = 0; i < s.len(); i++)
         directed_rows.push_back('{8'(s[i]), i == s.len() - 1,
                                   typed && i == s.len() - 1, found, id});
   endfunction

   // random frame: mostly keyword paths with random case, some noise and broken ones
   function automatic void build_frame(ref logic [7:0] f[$]);
      int kind, root, n;
      string kw;
      f.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(1, 40);
         repeat (n) f.push_back(8'($urandom));
         return;
      end
      if ($urandom_range(0, 3) == 0) f.push_back(":");
      root = $urandom_range(0, 3);
      kw = keyword_text[0][root];
      if (kind == 1) kw = {kw, "X"};
      for (int i = 0; i < kw.len(); i++)
         f.push_back(($urandom_range(0, 1) && kw[i] >= "A" && kw[i] <= "Z") ?
                     8'(kw[i]) | 8'h20 : 8'(kw[i]));
      if ($urandom_range(0, 7) != 0) begin
         repeat ($urandom_range(1, 2)) f.push_back(":");
         kw = keyword_text[root + 1][$urandom_range(0, 3)];
         if (kw.len() == 0 || kind == 2) kw = "VOLT";
         for (int i = 0; i < kw.len(); i++)
            f.push_back(($urandom_range(0, 1) && kw[i] >= "A" && kw[i] <= "Z") ?
                        8'(kw[i]) | 8'h20 : 8'(kw[i]));
      end
      if (kind == 3) repeat ($urandom_range(20, 70)) f.push_back("A");
      if (kind == 4) begin
         f.push_back(8'h00);
         f.push_back(":");
         f.push_back("Q");
      end
      if (kind == 5) begin
         f.push_back(8'($urandom_range(1, 255)));
         return;
      end
      case ($urandom_range(0, 2))
         0: f.push_back(8'h20);
         1: f.push_back(8'h0A);
         default: f.push_back(8'h0D);
      endcase
      repeat ($urandom_range(0, 3)) f.push_back(8'($urandom_range(9, 13)));
      n = (kind == 6) ? $urandom_range(30, 45) : $urandom_range(0, 8);
      repeat (n) f.push_back(8'($urandom));
      f.push_back(8'($urandom));
   endfunction

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      parse_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result transfer");
            failed = 1'b1;
         end else begin
            e = expected_q.pop_front();
            if (rsp_is_verdict !== e.is_verdict) begin
               $error("is_verdict: expected %0d, got %0d", e.is_verdict, rsp_is_verdict);
               failed = 1'b1;
            end
            if (rsp_arg_byte !== e.arg) begin
               $error("arg_byte: expected %0h, got %0h", e.arg, rsp_arg_byte);
               failed = 1'b1;
            end
            if (rsp_command_found !== e.found) begin
               $error("command_found: expected %0d, got %0d", e.found, rsp_command_found);
               failed = 1'b1;
            end
            if (rsp_command_id !== e.id) begin
               $error("command_id: expected %0d, got %0d", e.id, rsp_command_id);
               failed = 1'b1;
            end
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off
   initial begin
      int mode;
      repeat (8) @(posedge clock);
      repeat (300) begin
         @(posedge clock);
         rsp_ready <= $urandom_range(0, 3) != 0;
      end
      rsp_ready <= 1'b0;
      repeat (200) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(10, 80)) begin
            @(posedge clock);
            rsp_ready <= (mode == 0) ? 1'b1 :
                         (mode == 1) ? ($urandom_range(0, 1) == 1) :
                         ($urandom_range(0, 4) == 0);
         end
      end
   end

   // sender
   initial begin
      logic [7:0]   frame[$];
      stim_row_type row;
      int           burst_left;
      directed_rows.push_back('{8'h00, 1'b1, 1'b1, 1'b0, 3'd0});
      directed_rows.push_back('{8'hFF, 1'b1, 1'b1, 1'b0, 3'd0});
      add_frame("OUTPUT:ONOFF 1", 1'b1, 1'b1, 3'd6);
      add_frame("SYSTEM x", 1'b1, 1'b0, 3'd0);
      burst_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_byte(directed_rows[i]);
      while (bytes_sent < ITEMS_TARGET) begin
         build_frame(frame);
         foreach (frame[i]) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 2) != 0) begin
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            end
            burst_left--;
            row = '{frame[i], i == frame.size() - 1, 1'b0, 1'b0, 3'd0};
            send_byte(row);
         end
      end
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire
